[hdl/rtcp_pkg.sv]
// rtcp_pkg: shared types, register indexes and reset values for the rtc cmos block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtcp_pkg;

  localparam int unsigned StoreDepthDef = 128;
  localparam int unsigned IdxW          = 7;

  localparam logic [IdxW-1:0] RegA     = 7'd10;
  localparam logic [IdxW-1:0] RegB     = 7'd11;
  localparam logic [IdxW-1:0] RegC     = 7'd12;
  localparam logic [IdxW-1:0] RegD     = 7'd13;
  localparam logic [IdxW-1:0] RegBaseL = 7'h15;
  localparam logic [IdxW-1:0] RegBaseH = 7'h16;

  localparam logic [7:0] RegAReset     = 8'h26;
  localparam logic [7:0] RegBReset     = 8'h02;
  localparam logic [7:0] RegDReset     = 8'h80;
  localparam logic [7:0] RegBaseLReset = 8'h80;
  localparam logic [7:0] RegBaseHReset = 8'h02;

  localparam logic [7:0] AUip      = 8'h80;
  localparam logic [7:0] BPie      = 8'h40;
  localparam logic [7:0] CFlags    = 8'hc0;
  localparam logic [7:0] PortIdle  = 8'hff;
  localparam logic [3:0] RateSlow1 = 4'd1;
  localparam logic [3:0] RateSlow2 = 4'd2;
  localparam logic [3:0] RateShift = 4'd7;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic       data_port;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
  } out_t;

  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    logic [IdxW-1:0] addr;
    logic [7:0]      wdata;
  } store_req_t;

  function automatic logic [7:0] store_reset_val(input logic [IdxW-1:0] idx);
    logic [7:0] val;
    case (idx)
      RegA:     val = RegAReset;
      RegB:     val = RegBReset;
      RegD:     val = RegDReset;
      RegBaseL: val = RegBaseLReset;
      RegBaseH: val = RegBaseHReset;
      default:  val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[hdl/rtc_cmos_periodic_interrupt.sv]
// rtc_cmos_periodic_interrupt: index/data port cmos store with periodic interrupt timer
// depends on rtcp_pkg and rtcp_store
`timescale 1ns / 1ps
`default_nettype none

// Each transfer is a port read, a port write, one tick or a no-op, and gives exactly one
// result transfer. The store read is registered at acceptance and the result sits in one
// output register, so a new item is taken every cycle while the result is consumed.
// Registers A, B and C live in flops; the other bytes sit in a small memory whose entries
// read as their reset values until first written, so no clearing pass is needed after reset.
module rtc_cmos_periodic_interrupt import rtcp_pkg::*; #(
  parameter int unsigned STORE_DEPTH = StoreDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      reg_a_q, reg_a_d, reg_b_q, reg_b_d, reg_c_q, reg_c_d;
  logic [31:0]     tick_q, tick_d, deadline_q, deadline_d, tick_inc, tick_lag;
  logic [14:0]     period_q, period_d, arm_period;
  logic [31:0]     arm_sum;
  logic [3:0]      rate;
  logic            out_valid_q, sel_mem_q, sel_mem_d, in_range, arm, accept;
  out_t            out_q, out_d;
  store_req_t      store_req;
  logic [7:0]      store_rdata;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_range   = {1'b0, idx_q} < 8'(STORE_DEPTH);
  assign tick_inc   = tick_q + 32'd1;
  assign tick_lag   = tick_inc - deadline_q;

  // rate code of the updated register A, slow codes mapped up
  always_comb begin
    rate = reg_a_d[3:0];
    if (rate == RateSlow1 || rate == RateSlow2) begin
      rate = rate + RateShift;
    end
    arm_period = 15'd1 << (rate - 4'd1);
    arm_sum    = tick_q + {17'd0, arm_period};
  end

  always_comb begin
    idx_d      = idx_q;
    reg_a_d    = reg_a_q;
    reg_b_d    = reg_b_q;
    reg_c_d    = reg_c_q;
    tick_d     = tick_q;
    deadline_d = deadline_q;
    period_d   = period_q;
    out_d      = '0;
    sel_mem_d  = 1'b0;
    arm        = 1'b0;
    store_req        = '0;
    store_req.addr   = idx_q;
    store_req.wdata  = in_data_i.write_data;
    store_req.rd_en  = accept;
    case (in_data_i.func)
      FUNC_READ: begin
        if (!in_data_i.data_port || !in_range) begin
          out_d.read_data = PortIdle;
        end else if (idx_q == RegA) begin
          out_d.read_data = reg_a_q;
        end else if (idx_q == RegB) begin
          out_d.read_data = reg_b_q;
        end else if (idx_q == RegC) begin
          out_d.read_data = reg_c_q;
          reg_c_d         = 8'h00;
        end else begin
          sel_mem_d = 1'b1;
        end
      end
      FUNC_WRITE: begin
        if (!in_data_i.data_port) begin
          idx_d = in_data_i.write_data[IdxW-1:0];
        end else if (in_range) begin
          if (idx_q == RegA) begin
            reg_a_d = (in_data_i.write_data & ~AUip) | (reg_a_q & AUip);
            arm     = 1'b1;
          end else if (idx_q == RegB) begin
            reg_b_d = in_data_i.write_data;
            arm     = 1'b1;
          end else if (idx_q == RegC) begin
            reg_c_d = in_data_i.write_data;
          end else begin
            store_req.wr_en = accept;
          end
        end
      end
      FUNC_TICK: begin
        tick_d = tick_inc;
        if ((reg_b_q & BPie) != 8'h00 && !tick_lag[31]) begin
          reg_c_d         = reg_c_q | CFlags;
          out_d.irq_pulse = 1'b1;
          deadline_d      = deadline_q + {17'd0, period_q};
        end
      end
      default: begin
      end
    endcase
    if (arm && (reg_b_d & BPie) != 8'h00 && reg_a_d[3:0] != 4'd0) begin
      period_d   = arm_period;
      deadline_d = arm_sum & ~({17'd0, arm_period} - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      reg_a_q     <= RegAReset;
      reg_b_q     <= RegBReset;
      reg_c_q     <= 8'h00;
      tick_q      <= '0;
      deadline_q  <= '0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        idx_q      <= idx_d;
        reg_a_q    <= reg_a_d;
        reg_b_q    <= reg_b_d;
        reg_c_q    <= reg_c_d;
        tick_q     <= tick_d;
        deadline_q <= deadline_d;
        period_q   <= period_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q     <= out_d;
      sel_mem_q <= sel_mem_d;
    end
  end

  rtcp_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rdata_o(store_rdata)
  );

  assign out_valid_o          = out_valid_q;
  assign out_data_o.read_data = sel_mem_q ? store_rdata : out_q.read_data;
  assign out_data_o.irq_pulse = out_q.irq_pulse;

  a_period_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(period_q))
    else $error("period is not a power of two");

  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.irq_pulse |-> out_data_o.read_data == 8'h00)
    else $error("interrupt result carries read data");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  a_uip_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !reg_a_q[7])
    else $error("update-in-progress bit changed");

endmodule

`default_nettype wire

[hdl/rtcp_store.sv]
// rtcp_store: cmos byte store with per-entry valid bits and registered read data
// depends on rtcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtcp_store import rtcp_pkg::*; #(
  parameter int unsigned STORE_DEPTH = StoreDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire store_req_t req_i,
  output logic [7:0]      rdata_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic [AddrW-1:0]       addr;

  assign addr = req_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= valid_q[addr] ? mem[addr] : store_reset_val(req_i.addr);
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
